[rtl/core/bqc_pkg.sv]
// Shared types and constants for the cascaded biquad filter bank.
// Used by bqc_cell, bqc_gain and biquad_band_cascade; depends on nothing.
package bqc_pkg;

   localparam int NUM_CHANNELS = 2;
   localparam int NUM_BANDS    = 4;
   localparam int MAX_BANDS    = 4;

   localparam int SAMPLE_W   = 24;
   localparam int DATA_W     = 32;
   localparam int COEF_W     = 12;
   localparam int COEFS_W    = 5 * COEF_W;
   localparam int GAIN_W     = 16;
   localparam int CHAN_W     = 1;
   localparam int CHAN_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CSR_ADDR_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] REG_BAND0  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BAND1  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BAND2  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BAND3  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_ENABLE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN   = 3'd5;

   localparam logic [COEFS_W-1:0]  COEFS_RESET  = COEFS_W'(1024);
   localparam logic [MAX_BANDS-1:0] ENABLE_RESET = '1;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(4096);

   // word handed from cell to cell: Q9.23 value plus routing info
   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [CHAN_W-1:0] chan;
      logic              bypass;
   } cell_word_type;

endpackage

[rtl/core/bqc_cell.sv]
// One direct-form-I biquad section with per-channel x1/x2/y1/y2 history.
// Uses a single 12x32 multiplier over five steps. Depends on bqc_pkg.
module bqc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bqc_pkg::COEFS_W-1:0]   coeffs,
   input  logic                          enable,
   input  logic                          in_valid,
   input  bqc_pkg::cell_word_type        in_word,
   output logic                          out_valid,
   output bqc_pkg::cell_word_type        out_word
);

   localparam int PROD_W = bqc_pkg::COEF_W + bqc_pkg::DATA_W;
   localparam int ACC_W  = PROD_W + 4;
   localparam int HIST_TAPS = 4;
   localparam int RND_SHIFT = 10;

   localparam logic [2:0] STEP_B0   = 3'd0;
   localparam logic [2:0] STEP_B1   = 3'd1;
   localparam logic [2:0] STEP_B2   = 3'd2;
   localparam logic [2:0] STEP_A1   = 3'd3;
   localparam logic [2:0] STEP_A2   = 3'd4;
   localparam logic [2:0] STEP_DONE = 3'd5;

   localparam logic [1:0] H_X1 = 2'd0;
   localparam logic [1:0] H_X2 = 2'd1;
   localparam logic [1:0] H_Y1 = 2'd2;
   localparam logic [1:0] H_Y2 = 2'd3;

   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(512);
   localparam logic signed [ACC_W-1:0] Y_MAX    = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] Y_MIN    = -ACC_W'(64'sd2147483648);

   typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_ROUND} state_type;

   state_type                     state_ff;
   logic [2:0]                    step_ff;
   bqc_pkg::cell_word_type        word_ff;
   bqc_pkg::cell_word_type        out_word_ff;
   logic                          out_vld_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic                          sub_ff;
   logic                          prod_vld_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [bqc_pkg::DATA_W-1:0] hist_ff [bqc_pkg::NUM_CHANNELS][HIST_TAPS];

   logic [bqc_pkg::CHAN_IDX_W-1:0]    ch;
   logic signed [bqc_pkg::COEF_W-1:0] coef_sel;
   logic signed [bqc_pkg::DATA_W-1:0] op_sel;
   logic signed [PROD_W-1:0]          prod_in;
   logic signed [ACC_W-1:0]           acc_in;
   logic signed [ACC_W-1:0]           rnd_full;
   logic signed [bqc_pkg::DATA_W-1:0] y_in;

   assign ch = bqc_pkg::CHAN_IDX_W'(word_ff.chan);

   always_comb begin
      case (step_ff)
         STEP_B0: begin
            coef_sel = coeffs[0 +: bqc_pkg::COEF_W];
            op_sel   = word_ff.x;
         end
         STEP_B1: begin
            coef_sel = coeffs[bqc_pkg::COEF_W +: bqc_pkg::COEF_W];
            op_sel   = hist_ff[ch][H_X1];
         end
         STEP_B2: begin
            coef_sel = coeffs[2 * bqc_pkg::COEF_W +: bqc_pkg::COEF_W];
            op_sel   = hist_ff[ch][H_X2];
         end
         STEP_A1: begin
            coef_sel = coeffs[3 * bqc_pkg::COEF_W +: bqc_pkg::COEF_W];
            op_sel   = hist_ff[ch][H_Y1];
         end
         STEP_A2: begin
            coef_sel = coeffs[4 * bqc_pkg::COEF_W +: bqc_pkg::COEF_W];
            op_sel   = hist_ff[ch][H_Y2];
         end
         default: begin
            coef_sel = '0;
            op_sel   = '0;
         end
      endcase
   end

   assign prod_in  = coef_sel * op_sel;
   assign acc_in   = sub_ff ? acc_ff - ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
   // round half up: add half an LSB, then floor shift
   assign rnd_full = (acc_ff + ACC_HALF) >>> RND_SHIFT;

   always_comb begin
      if (rnd_full > Y_MAX) begin
         y_in = bqc_pkg::DATA_W'(Y_MAX);
      end else if (rnd_full < Y_MIN) begin
         y_in = bqc_pkg::DATA_W'(Y_MIN);
      end else begin
         y_in = bqc_pkg::DATA_W'(rnd_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         for (int c = 0; c < bqc_pkg::NUM_CHANNELS; c++) begin
            for (int t = 0; t < HIST_TAPS; t++) begin
               hist_ff[c][t] <= '0;
            end
         end
      end else begin
         out_vld_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  if (!enable || in_word.bypass) begin
                     // skipped section: pass the word on untouched
                     out_word_ff <= in_word;
                     out_vld_ff  <= 1'b1;
                  end else begin
                     word_ff     <= in_word;
                     step_ff     <= STEP_B0;
                     acc_ff      <= '0;
                     prod_vld_ff <= 1'b0;
                     state_ff    <= ST_MAC;
                  end
               end
            end
            ST_MAC: begin
               if (step_ff != STEP_DONE) begin
                  prod_ff <= prod_in;
                  sub_ff  <= (step_ff == STEP_A1) || (step_ff == STEP_A2);
               end
               prod_vld_ff <= (step_ff != STEP_DONE);
               if (prod_vld_ff) begin
                  acc_ff <= acc_in;
               end
               if (step_ff == STEP_DONE) begin
                  state_ff <= ST_ROUND;
               end
               step_ff <= step_ff + 3'd1;
            end
            ST_ROUND: begin
               hist_ff[ch][H_X2] <= hist_ff[ch][H_X1];
               hist_ff[ch][H_X1] <= word_ff.x;
               hist_ff[ch][H_Y2] <= hist_ff[ch][H_Y1];
               hist_ff[ch][H_Y1] <= y_in;
               out_word_ff.x      <= y_in;
               out_word_ff.chan   <= word_ff.chan;
               out_word_ff.bypass <= 1'b0;
               out_vld_ff         <= 1'b1;
               state_ff           <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign out_valid = out_vld_ff;
   assign out_word  = out_word_ff;

endmodule

[rtl/core/bqc_gain.sv]
// Final insertion gain, rounding and 24-bit saturation, holding its result
// until the output register takes it. Depends on bqc_pkg.
module bqc_gain (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bqc_pkg::GAIN_W-1:0]     gain,
   input  logic                           in_valid,
   input  bqc_pkg::cell_word_type         in_word,
   input  logic                           out_ready,
   output logic                           out_valid,
   output logic [bqc_pkg::SAMPLE_W-1:0]   out_sample
);

   localparam int GPROD_W   = bqc_pkg::DATA_W + bqc_pkg::GAIN_W + 1;
   localparam int RND_SHIFT = 12;

   localparam logic signed [GPROD_W-1:0] G_HALF = GPROD_W'(2048);
   localparam logic signed [GPROD_W-1:0] S_MAX  = GPROD_W'(8388607);
   localparam logic signed [GPROD_W-1:0] S_MIN  = -GPROD_W'(8388608);

   logic                              hold_ff;
   logic                              bypass_ff;
   logic signed [GPROD_W-1:0]         prod_ff;
   logic [bqc_pkg::SAMPLE_W-1:0]      x_ff;

   logic signed [GPROD_W-1:0]         prod_in;
   logic signed [GPROD_W-1:0]         rnd_full;
   logic [bqc_pkg::SAMPLE_W-1:0]      sat_val;

   assign prod_in  = $signed(in_word.x) * $signed({1'b0, gain});
   assign rnd_full = (prod_ff + G_HALF) >>> RND_SHIFT;

   always_comb begin
      if (rnd_full > S_MAX) begin
         sat_val = bqc_pkg::SAMPLE_W'(S_MAX);
      end else if (rnd_full < S_MIN) begin
         sat_val = bqc_pkg::SAMPLE_W'(S_MIN);
      end else begin
         sat_val = bqc_pkg::SAMPLE_W'(rnd_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else if (in_valid) begin
         hold_ff   <= 1'b1;
         prod_ff   <= prod_in;
         bypass_ff <= in_word.bypass;
         x_ff      <= in_word.x[bqc_pkg::SAMPLE_W-1:0];
      end else if (out_ready) begin
         hold_ff <= 1'b0;
      end
   end

   assign out_valid  = hold_ff;
   // out-of-range channel: raw sample, no gain
   assign out_sample = bypass_ff ? x_ff : sat_val;

endmodule

[rtl/core/biquad_band_cascade.sv]
// Cascaded biquad filter bank: a row of section cells, then the gain stage.
// Each enabled band accepts the word, runs its multiply-accumulate steps and rounds;
// a skipped band passes it on through one register; then come the gain stage and output register.
// One word is in the section row at a time; the next word is not taken until the result
// moves into the output register (which can stall on rsp_tready); req_tready rises with rsp_tvalid.
// Reset (synchronous) clears all filter history and restores identity coefficients.
module biquad_band_cascade (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bqc_pkg::SAMPLE_W-1:0]      req_tdata,   // [23:0] sample_in
   input  logic [bqc_pkg::CHAN_W-1:0]        req_tuser,   // [0] chan
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bqc_pkg::SAMPLE_W-1:0]      rsp_tdata,   // [23:0] sample_out
   input  logic                              csr_we,
   input  logic [bqc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [bqc_pkg::COEFS_W-1:0]       csr_wdata
);

   logic [bqc_pkg::COEFS_W-1:0]   coeffs_ff [bqc_pkg::MAX_BANDS];
   logic [bqc_pkg::MAX_BANDS-1:0] enable_ff;
   logic [bqc_pkg::GAIN_W-1:0]    gain_ff;
   logic                          busy_ff;
   logic                          rsp_vld_ff;
   logic [bqc_pkg::SAMPLE_W-1:0]  rsp_data_ff;

   logic                          cell_vld  [bqc_pkg::NUM_BANDS + 1];
   bqc_pkg::cell_word_type        cell_word [bqc_pkg::NUM_BANDS + 1];
   logic                          g_valid;
   logic                          g_ready;
   logic [bqc_pkg::SAMPLE_W-1:0]  g_sample;
   logic                          req_fire;

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && !busy_ff;

   assign cell_vld[0]         = req_fire;
   assign cell_word[0].x      = bqc_pkg::DATA_W'($signed(req_tdata));
   assign cell_word[0].chan   = req_tuser;
   assign cell_word[0].bypass = int'(req_tuser) >= bqc_pkg::NUM_CHANNELS;

   for (genvar b = 0; b < bqc_pkg::NUM_BANDS; b++) begin : g_band
      bqc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .coeffs    (coeffs_ff[b]),
         .enable    (enable_ff[b]),
         .in_valid  (cell_vld[b]),
         .in_word   (cell_word[b]),
         .out_valid (cell_vld[b+1]),
         .out_word  (cell_word[b+1])
      );
   end

   bqc_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .gain       (gain_ff),
      .in_valid   (cell_vld[bqc_pkg::NUM_BANDS]),
      .in_word    (cell_word[bqc_pkg::NUM_BANDS]),
      .out_ready  (g_ready),
      .out_valid  (g_valid),
      .out_sample (g_sample)
   );

   assign g_ready = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < bqc_pkg::MAX_BANDS; b++) begin
            coeffs_ff[b] <= bqc_pkg::COEFS_RESET;
         end
         enable_ff <= bqc_pkg::ENABLE_RESET;
         gain_ff   <= bqc_pkg::GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr) inside
            bqc_pkg::REG_BAND0, bqc_pkg::REG_BAND1,
            bqc_pkg::REG_BAND2, bqc_pkg::REG_BAND3: begin
               coeffs_ff[csr_addr[1:0]] <= csr_wdata;
            end
            bqc_pkg::REG_ENABLE: begin
               enable_ff <= csr_wdata[bqc_pkg::MAX_BANDS-1:0];
            end
            bqc_pkg::REG_GAIN: begin
               gain_ff <= csr_wdata[bqc_pkg::GAIN_W-1:0];
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (g_valid && g_ready) begin
            busy_ff     <= 1'b0;
            rsp_vld_ff  <= 1'b1;
            rsp_data_ff <= g_sample;
         end else begin
            if (req_fire) begin
               busy_ff <= 1'b1;
            end
            if (rsp_tready) begin
               rsp_vld_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sim/biquad_band_cascade_test.sv]
// Self-checking testbench for biquad_band_cascade: random and directed audio words, a
// cycle-free predictor of the four-section cascade, and random stalls on both streams.
// Depends on bqc_pkg and the biquad_band_cascade RTL only.
module biquad_band_cascade_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bqc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PHASES = 12;
   localparam int WORDS_PER_PHASE = 155;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [CHAN_W-1:0]   chan;
   } audio_word_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;   // [23:0] sample_in
   logic [CHAN_W-1:0]     req_tuser = '0;   // [0] chan
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;        // [23:0] sample_out
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [COEFS_W-1:0]    csr_wdata = '0;

   // filter state as the block should hold it
   logic [COEFS_W-1:0] band_coefs [NUM_BANDS];
   logic [MAX_BANDS-1:0] band_on;
   logic [GAIN_W-1:0] gain_q412;
   int hx1 [NUM_CHANNELS][NUM_BANDS];
   int hx2 [NUM_CHANNELS][NUM_BANDS];
   int hy1 [NUM_CHANNELS][NUM_BANDS];
   int hy2 [NUM_CHANNELS][NUM_BANDS];

   audio_word_t sample_backlog [$];
   logic [SAMPLE_W-1:0] awaited_samples [$];

   int  fault_count = 0;
   int  words_taken = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   int  req_idle_pct = 30;
   int  rsp_idle_pct = 30;
   bit  req_taken = 1'b0;
   bit  rsp_hold = 1'b0;

   biquad_band_cascade u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         band_coefs[b] = COEFS_RESET;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            hx1[c][b] = 0;
            hx2[c][b] = 0;
            hy1[c][b] = 0;
            hy2[c][b] = 0;
         end
      end
      band_on = ENABLE_RESET;
      gain_q412 = GAIN_RESET;
   end

   // Run one word through the enabled sections and the gain, updating the history.
   function automatic logic [SAMPLE_W-1:0] filter_sample(logic [SAMPLE_W-1:0] din,
                                                         logic [CHAN_W-1:0] ch);
      longint x, acc, y, g, r;
      longint cf [5];
      int b, k;
      x = longint'($signed(din));
      if (ch >= NUM_CHANNELS) return din;
      for (b = 0; b < NUM_BANDS; b++) begin
         if (band_on[b]) begin
            for (k = 0; k < 5; k++) begin
               cf[k] = longint'($signed(band_coefs[b][COEF_W*k +: COEF_W]));
            end
            acc = cf[0] * x + cf[1] * longint'(hx1[ch][b]) + cf[2] * longint'(hx2[ch][b])
                - cf[3] * longint'(hy1[ch][b]) - cf[4] * longint'(hy2[ch][b]);
            y = (acc + 512) >>> 10;
            if (y > 64'sd2147483647) y = 64'sd2147483647;
            if (y < -64'sd2147483648) y = -64'sd2147483648;
            hx2[ch][b] = hx1[ch][b];
            hx1[ch][b] = int'(x);
            hy2[ch][b] = hy1[ch][b];
            hy1[ch][b] = int'(y);
            x = y;
         end
      end
      g = x * longint'(gain_q412);
      r = (g + 2048) >>> 12;
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      return r[SAMPLE_W-1:0];
   endfunction

   // no gap unless the idle percentage is hit, then mostly a short gap, rarely a long one
   function automatic int pick_gap(int idle_pct);
      if ($urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(60, 20);
      return $urandom_range(4, 1);
   endfunction

   // Either arbitrary bits or a stable section with random zeros.
   function automatic logic [COEFS_W-1:0] random_coefs();
      int a1, a2, lim;
      logic [COEF_W-1:0] b0, b1, b2;
      if ($urandom_range(3) == 0) return COEFS_W'({$urandom, $urandom});
      a2 = $urandom_range(1800) - 900;
      lim = 1024 + a2 - 40;
      a1 = $urandom_range(2 * lim) - lim;
      b0 = COEF_W'($urandom);
      b1 = COEF_W'($urandom);
      b2 = COEF_W'($urandom);
      return {a2[COEF_W-1:0], a1[COEF_W-1:0], b2, b1, b0};
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         6, 7: return SAMPLE_W'($urandom_range(8192) - 4096);
         8: begin
            case ($urandom_range(3))
               0: return 24'h7FFFFF;
               1: return 24'h800000;
               2: return 24'h000000;
               default: return 24'hFFFFFF;
            endcase
         end
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [COEFS_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      case (addr)
         REG_BAND0, REG_BAND1, REG_BAND2, REG_BAND3: band_coefs[addr[1:0]] = data;
         REG_ENABLE: band_on = data[MAX_BANDS-1:0];
         REG_GAIN: gain_q412 = data[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // Write every register, upper bits of the narrow ones filled with junk, plus a spare index.
   task automatic configure(logic [COEFS_W-1:0] c0, logic [COEFS_W-1:0] c1,
                            logic [COEFS_W-1:0] c2, logic [COEFS_W-1:0] c3,
                            logic [MAX_BANDS-1:0] en, logic [GAIN_W-1:0] g);
      logic [COEFS_W-1:0] junk;
      junk = COEFS_W'({$urandom, $urandom});
      write_reg(REG_BAND0, c0);
      write_reg(REG_BAND1, c1);
      write_reg(REG_BAND2, c2);
      write_reg(REG_BAND3, c3);
      write_reg(REG_ENABLE, {junk[COEFS_W-1:MAX_BANDS], en});
      write_reg(REG_GAIN, {junk[COEFS_W-1:GAIN_W], g});
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, ~junk);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_word(logic [SAMPLE_W-1:0] s, logic [CHAN_W-1:0] ch);
      audio_word_t w;
      w.sample = s;
      w.chan = ch;
      sample_backlog.push_back(w);
   endtask

   task automatic drain();
      while (sample_backlog.size() != 0 || awaited_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sender: hold a word until taken, then idle or present the next one
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (sample_backlog.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= sample_backlog[0].sample;
            req_tuser <= sample_backlog[0].chan;
            req_gap = pick_gap(req_idle_pct);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap(rsp_idle_pct);
      end
   end

   // monitor: check results against the oldest prediction, predict accepted words
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_samples.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected word: sample_out %0d", $signed(rsp_tdata));
         end else begin
            if (rsp_tdata !== awaited_samples[0]) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("sample_out mismatch: expected %0d, got %0d",
                           $signed(awaited_samples[0]), $signed(rsp_tdata));
            end
            void'(awaited_samples.pop_front());
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         awaited_samples.push_back(filter_sample(req_tdata, req_tuser));
         void'(sample_backlog.pop_front());
         words_taken++;
         req_taken = 1'b1;
      end
   end

   // back-pressure: stop reading long enough for the block to fill and stall its input
   initial begin
      while (words_taken < 400) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("biquad_band_cascade regression: fail");
      $finish;
   end

   initial begin
      logic [SAMPLE_W-1:0] extremes [6];
      logic [COEFS_W-1:0] c [NUM_BANDS];
      logic [MAX_BANDS-1:0] en;
      logic [GAIN_W-1:0] g;
      extremes = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h7FFFFF};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity sections at unity gain
      configure(COEFS_RESET, COEFS_RESET, COEFS_RESET, COEFS_RESET, ENABLE_RESET, GAIN_RESET);
      for (int i = 0; i < 6; i++) queue_word(extremes[i], CHAN_W'(i));
      drain();

      // all sections off, gain alone at its maximum
      configure(COEFS_RESET, COEFS_RESET, COEFS_RESET, COEFS_RESET, '0, '1);
      for (int i = 0; i < 4; i++) queue_word(extremes[i + 1], CHAN_W'(i));
      drain();

      // extreme coefficients drive the feedback into saturation
      configure(60'h800800800800800, 60'h7FF7FF7FF7FF7FF, '0, '1, '1, GAIN_RESET);
      for (int i = 0; i < 8; i++) queue_word(i[0] ? 24'h800000 : 24'h7FFFFF, CHAN_W'(i >> 1));
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int b = 0; b < NUM_BANDS; b++) c[b] = random_coefs();
         en = MAX_BANDS'($urandom);
         g = $urandom_range(3) == 0 ? GAIN_W'($urandom) : GAIN_W'($urandom_range(8192));
         case (p)
            0: g = '0;
            1: g = '1;
            2: for (int b = 0; b < NUM_BANDS; b++) c[b] = '0;
            4: en = '0;
            5: en = '1;
            default: ;
         endcase
         req_idle_pct = (p == 3) ? 0 : 30 * $urandom_range(2);
         rsp_idle_pct = (p == 3) ? 0 : 30 * $urandom_range(2);
         configure(c[0], c[1], c[2], c[3], en, g);
         for (int i = 0; i < WORDS_PER_PHASE; i++)
            queue_word(random_sample(), CHAN_W'($urandom));
         drain();
      end

      if (fault_count == 0 && awaited_samples.size() == 0) begin
         $display("biquad_band_cascade regression: pass");
      end else begin
         $display("biquad_band_cascade regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/bqc_pkg.sv
rtl/core/bqc_cell.sv
rtl/core/bqc_gain.sv
rtl/core/biquad_band_cascade.sv
sim/biquad_band_cascade_test.sv
